FILE: hw/rtl/wzcf_pkg.sv
// ----------------------------------------------------------------------------
// wzcf_pkg: shared constants for the zero-crossing frequency unit
// Window and cell sizes, derived field widths and register indexes.
// ----------------------------------------------------------------------------
package wzcf_pkg;

    localparam int WINDOW    = 32;
    localparam int MAX_CELLS = 64;

    localparam int POS_W   = $clog2(WINDOW);
    localparam int CNT_W   = $clog2(WINDOW + 1);
    localparam int CELL_W  = 6;
    localparam int CIU_W   = 7;
    localparam int ADDR_W  = CELL_W + POS_W;
    localparam int DEPTH   = MAX_CELLS * WINDOW;
    localparam int SMP_W   = 16;
    localparam int RATE_W  = 16;
    localparam int THR_W   = 32;
    localparam int FREQ_W  = 23;
    localparam int SUM_W   = SMP_W + POS_W;
    localparam int SQ_W    = 2 * SMP_W - 1 + POS_W;
    localparam int NX_W    = SMP_W + CNT_W + 1;
    localparam int VAR_W   = 2 * SUM_W;
    localparam int LIM_W   = THR_W + 2 * CNT_W;
    localparam int ZC_W    = POS_W;
    localparam int NUM_W   = ZC_W + RATE_W + 7;
    localparam int MIN_N   = 4;

    localparam logic [1:0] REG_SAMPLE_RATE  = 2'd0;
    localparam logic [1:0] REG_CELLS_IN_USE = 2'd1;
    localparam logic [1:0] REG_VAR_THRESH   = 2'd2;

endpackage

FILE: hw/rtl/wzcf_ram.sv
// ----------------------------------------------------------------------------
// wzcf_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module wzcf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/wzcf_div.sv
// ----------------------------------------------------------------------------
// wzcf_div: restoring divider, one quotient bit per cycle
// Divides the scaled crossing count by the sample count.
// ----------------------------------------------------------------------------
module wzcf_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [wzcf_pkg::NUM_W-1:0]   i_num,
    input  logic [wzcf_pkg::CNT_W-1:0]   i_den,
    output logic                         o_done,
    output logic [wzcf_pkg::NUM_W-1:0]   o_quot
);

    localparam int STEP_W = $clog2(wzcf_pkg::NUM_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(wzcf_pkg::NUM_W - 1);

    logic                        r_busy;
    logic                        r_done;
    logic [STEP_W-1:0]           r_step;
    logic [wzcf_pkg::CNT_W-1:0]  r_den;
    logic [wzcf_pkg::CNT_W-1:0]  r_rem;
    logic [wzcf_pkg::NUM_W-1:0]  r_q;
    logic [wzcf_pkg::CNT_W:0]    n_trial;
    logic                        n_bit;

    // trial subtract of the next numerator bit
    always_comb begin
        n_trial = {r_rem, r_q[wzcf_pkg::NUM_W-1]};
        n_bit   = (n_trial >= {1'b0, r_den});
    end

    // shift one bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= i_den;
            r_rem <= '0;
            r_q   <= i_num;
        end else if (r_busy) begin
            if (n_bit) begin
                r_rem <= wzcf_pkg::CNT_W'(n_trial - {1'b0, r_den});
            end else begin
                r_rem <= n_trial[wzcf_pkg::CNT_W-1:0];
            end
            r_q <= {r_q[wzcf_pkg::NUM_W-2:0], n_bit};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

FILE: hw/rtl/windowed_zero_crossing_frequency_unit.sv
// ----------------------------------------------------------------------------
// windowed_zero_crossing_frequency_unit: per-cell zero-crossing frequency
// Keeps a sample ring per cell and, on request, reports frequency and
// activity for every cell plus the peak frequency over active cells.
// ----------------------------------------------------------------------------
//  channel  | handshake                  | payload
//  input    | i_valid / o_stall          | i_kind, i_sample_value
//  result   | o_valid / i_stall          | o_cell_index, o_freq_q8, o_active,
//           |                            | o_peak_freq_q8, o_last
//  config   | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
//  Sample pushes may follow back to back.
//  An analysis steps per cell through a sum pass and a crossing pass over
//  the stored samples on the single RAM read port, a multiply step, a
//  subtract step, the bit-serial divider and an output step; with fewer
//  than 4 samples stored each cell goes straight to the output step.
//  After reset a clearing pass zeroes all 2048 history RAM words; no
//  transaction is accepted meanwhile, configuration writes are.
//  A stalled result holds the unit until taken.
// ----------------------------------------------------------------------------
module windowed_zero_crossing_frequency_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic                               i_kind,
    input  logic signed [wzcf_pkg::SMP_W-1:0]  i_sample_value,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [wzcf_pkg::CELL_W-1:0]        o_cell_index,
    output logic [wzcf_pkg::FREQ_W-1:0]        o_freq_q8,
    output logic                               o_active,
    output logic [wzcf_pkg::FREQ_W-1:0]        o_peak_freq_q8,
    output logic                               o_last,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [1:0]                         i_cfg_index,
    input  logic [31:0]                        i_cfg_data
);

    localparam logic [2:0] ST_CLR  = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_SUM  = 3'd2;
    localparam logic [2:0] ST_XING = 3'd3;
    localparam logic [2:0] ST_MUL  = 3'd4;
    localparam logic [2:0] ST_SUB  = 3'd5;
    localparam logic [2:0] ST_DIV  = 3'd6;
    localparam logic [2:0] ST_OUT  = 3'd7;

    localparam int CW = wzcf_pkg::CELL_W;
    localparam int PW = wzcf_pkg::POS_W;
    localparam int NW = wzcf_pkg::CNT_W;
    localparam int AW = wzcf_pkg::ADDR_W;

    logic [2:0]                          r_state;
    logic [AW-1:0]                       r_clr;
    logic [wzcf_pkg::RATE_W-1:0]         r_rate;
    logic [wzcf_pkg::CIU_W-1:0]          r_cells_cfg;
    logic [wzcf_pkg::THR_W-1:0]          r_thr;
    logic [PW-1:0]                       r_wpos;
    logic [NW-1:0]                       r_fill;
    logic [CW-1:0]                       r_cpos;

    logic [NW-1:0]                       r_n;
    logic [CW-1:0]                       r_cell;
    logic [NW-1:0]                       r_j;
    logic                                r_dv;
    logic                                r_first;
    logic                                r_prev;
    logic signed [wzcf_pkg::SUM_W-1:0]   r_s;
    logic [wzcf_pkg::SQ_W-1:0]           r_q;
    logic [wzcf_pkg::ZC_W-1:0]           r_zc;
    logic [wzcf_pkg::VAR_W-1:0]          r_nq;
    logic [wzcf_pkg::VAR_W-1:0]          r_ss;
    logic [wzcf_pkg::LIM_W-1:0]          r_tn;
    logic [wzcf_pkg::ZC_W+wzcf_pkg::RATE_W-1:0] r_zr;
    logic [wzcf_pkg::VAR_W-1:0]          r_d;
    logic [wzcf_pkg::LIM_W-1:0]          r_lim;
    logic                                r_div_go;
    logic [wzcf_pkg::FREQ_W-1:0]         r_peak;

    logic                                r_oval;
    logic [CW-1:0]                       r_ocell;
    logic [wzcf_pkg::FREQ_W-1:0]         r_ofreq;
    logic                                r_oact;
    logic [wzcf_pkg::FREQ_W-1:0]         r_opeak;
    logic                                r_olast;

    logic [wzcf_pkg::CIU_W-1:0]          n_cells;
    logic                                n_in_acc;
    logic                                n_out_acc;
    logic                                n_we;
    logic [AW-1:0]                       n_waddr;
    logic [wzcf_pkg::SMP_W-1:0]          n_wdata;
    logic [AW-1:0]                       n_raddr;
    logic [wzcf_pkg::SMP_W-1:0]          n_rdata;
    logic signed [wzcf_pkg::SMP_W-1:0]   n_x;
    logic signed [2*wzcf_pkg::SMP_W-1:0] n_xx;
    logic signed [wzcf_pkg::NX_W-1:0]    n_nx;
    logic signed [wzcf_pkg::NX_W-1:0]    n_diff;
    logic                                n_sign;
    logic                                n_cell_last;
    logic                                n_act;
    logic [wzcf_pkg::NUM_W-1:0]          n_quot;
    logic                                n_div_done;
    logic [wzcf_pkg::FREQ_W-1:0]         n_freq;

    // effective cell count, clamped to one..MAX_CELLS
    always_comb begin
        priority if (r_cells_cfg == '0) begin
            n_cells = wzcf_pkg::CIU_W'(1);
        end else if (r_cells_cfg > wzcf_pkg::CIU_W'(wzcf_pkg::MAX_CELLS)) begin
            n_cells = wzcf_pkg::CIU_W'(wzcf_pkg::MAX_CELLS);
        end else begin
            n_cells = r_cells_cfg;
        end
    end

    assign o_stall     = (r_state != ST_IDLE);
    assign n_in_acc    = i_valid && !o_stall;
    assign n_out_acc   = r_oval && !i_stall;
    assign o_cfg_ready = 1'b1;
    assign n_cell_last = (({1'b0, r_cell} + 1'b1) == n_cells);

    // RAM write: clearing pass or sample push
    always_comb begin
        n_we    = 1'b0;
        n_waddr = {r_cpos, r_wpos};
        n_wdata = i_sample_value;
        if (r_state == ST_CLR) begin
            n_we    = 1'b1;
            n_waddr = r_clr;
            n_wdata = '0;
        end else if (n_in_acc && !i_kind) begin
            n_we = 1'b1;
        end
    end

    // oldest stored sample first
    assign n_raddr = {r_cell, PW'(r_wpos - r_n[PW-1:0] + r_j[PW-1:0])};

    wzcf_ram #(
        .WIDTH (wzcf_pkg::SMP_W),
        .DEPTH (wzcf_pkg::DEPTH)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (n_we),
        .i_waddr (n_waddr),
        .i_wdata (n_wdata),
        .i_raddr (n_raddr),
        .o_rdata (n_rdata)
    );

    // sample arithmetic: square, scaled sample against the sum; activity and frequency
    always_comb begin
        n_x    = $signed(n_rdata);
        n_xx   = n_x * n_x;
        n_nx   = $signed({1'b0, r_n}) * n_x;
        n_diff = n_nx - wzcf_pkg::NX_W'(r_s);
        n_sign = !n_diff[wzcf_pkg::NX_W-1];
        n_act  = {{(wzcf_pkg::LIM_W - wzcf_pkg::VAR_W){1'b0}}, r_d} > r_lim;
        n_freq = n_quot[wzcf_pkg::FREQ_W-1:0];
    end

    wzcf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_go),
        .i_num   ({r_zr, 7'd0}),
        .i_den   (r_n),
        .o_done  (n_div_done),
        .o_quot  (n_quot)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate      <= wzcf_pkg::RATE_W'(1000);
            r_cells_cfg <= wzcf_pkg::CIU_W'(wzcf_pkg::MAX_CELLS);
            r_thr       <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                wzcf_pkg::REG_SAMPLE_RATE:  r_rate      <= i_cfg_data[wzcf_pkg::RATE_W-1:0];
                wzcf_pkg::REG_CELLS_IN_USE: r_cells_cfg <= i_cfg_data[wzcf_pkg::CIU_W-1:0];
                wzcf_pkg::REG_VAR_THRESH:   r_thr       <= i_cfg_data[wzcf_pkg::THR_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLR;
            r_clr    <= '0;
            r_wpos   <= '0;
            r_fill   <= '0;
            r_cpos   <= '0;
            r_oval   <= 1'b0;
            r_dv     <= 1'b0;
            r_div_go <= 1'b0;
        end else begin
            r_div_go <= 1'b0;
            r_dv     <= 1'b0;
            unique case (r_state)
                ST_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == AW'(wzcf_pkg::DEPTH - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (n_in_acc && !i_kind) begin
                        // advance cell, and the ring at frame end
                        if (({1'b0, r_cpos} + 1'b1) >= n_cells) begin
                            r_cpos <= '0;
                            r_wpos <= r_wpos + 1'b1;
                            if (r_fill < NW'(wzcf_pkg::WINDOW)) begin
                                r_fill <= r_fill + 1'b1;
                            end
                        end else begin
                            r_cpos <= r_cpos + 1'b1;
                        end
                    end else if (n_in_acc) begin
                        r_n     <= r_fill;
                        r_cell  <= '0;
                        r_j     <= '0;
                        r_s     <= '0;
                        r_q     <= '0;
                        r_zc    <= '0;
                        r_peak  <= '0;
                        if (r_fill < NW'(wzcf_pkg::MIN_N)) begin
                            r_state <= ST_OUT;
                            r_oval  <= 1'b1;
                            r_ocell <= '0;
                            r_ofreq <= '0;
                            r_oact  <= 1'b0;
                            r_opeak <= '0;
                            r_olast <= (n_cells == wzcf_pkg::CIU_W'(1));
                        end else begin
                            r_state <= ST_SUM;
                        end
                    end
                end
                ST_SUM: begin
                    if (r_j < r_n) begin
                        r_j  <= r_j + 1'b1;
                        r_dv <= 1'b1;
                    end
                    if (r_dv) begin
                        r_s <= r_s + wzcf_pkg::SUM_W'(n_x);
                        r_q <= r_q + wzcf_pkg::SQ_W'(unsigned'(n_xx));
                    end
                    if (r_j == r_n && !r_dv) begin
                        r_state <= ST_XING;
                        r_j     <= '0;
                        r_first <= 1'b1;
                    end
                end
                ST_XING: begin
                    if (r_j < r_n) begin
                        r_j  <= r_j + 1'b1;
                        r_dv <= 1'b1;
                    end
                    if (r_dv) begin
                        r_prev  <= n_sign;
                        r_first <= 1'b0;
                        if (!r_first && n_sign != r_prev) begin
                            r_zc <= r_zc + 1'b1;
                        end
                    end
                    if (r_j == r_n && !r_dv) begin
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    r_nq    <= wzcf_pkg::VAR_W'(r_n) * r_q;
                    r_ss    <= wzcf_pkg::VAR_W'(unsigned'(wzcf_pkg::VAR_W'(r_s)
                                                          * wzcf_pkg::VAR_W'(r_s)));
                    r_tn    <= wzcf_pkg::LIM_W'(r_thr) * wzcf_pkg::LIM_W'(r_n);
                    r_zr    <= r_zc * r_rate;
                    r_state <= ST_SUB;
                end
                ST_SUB: begin
                    r_d      <= r_nq - r_ss;
                    r_lim    <= r_tn * wzcf_pkg::LIM_W'(r_n);
                    r_div_go <= 1'b1;
                    r_state  <= ST_DIV;
                end
                ST_DIV: begin
                    if (n_div_done) begin
                        r_state <= ST_OUT;
                        r_oval  <= 1'b1;
                        r_ocell <= r_cell;
                        r_ofreq <= n_freq;
                        r_oact  <= n_act;
                        r_olast <= n_cell_last;
                        r_opeak <= '0;
                        if (n_cell_last) begin
                            r_opeak <= (n_act && n_freq > r_peak) ? n_freq : r_peak;
                        end
                        if (n_act && n_freq > r_peak) begin
                            r_peak <= n_freq;
                        end
                    end
                end
                ST_OUT: begin
                    if (n_out_acc) begin
                        r_oval <= 1'b0;
                        if (r_olast) begin
                            r_state <= ST_IDLE;
                        end else if (r_n < NW'(wzcf_pkg::MIN_N)) begin
                            // short history: next zero result at once
                            r_oval  <= 1'b1;
                            r_cell  <= r_cell + 1'b1;
                            r_ocell <= r_cell + 1'b1;
                            r_olast <= (({1'b0, r_cell} + 7'd2) == n_cells);
                        end else begin
                            r_cell  <= r_cell + 1'b1;
                            r_j     <= '0;
                            r_s     <= '0;
                            r_q     <= '0;
                            r_zc    <= '0;
                            r_state <= ST_SUM;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_valid        = r_oval;
    assign o_cell_index   = r_ocell;
    assign o_freq_q8      = r_ofreq;
    assign o_active       = r_oact;
    assign o_peak_freq_q8 = r_opeak;
    assign o_last         = r_olast;

`ifndef SYNTHESIS
    a_no_accept_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_oval |-> o_stall)
        else $error("input taken while a result is pending");

    a_peak_only_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_oval && !r_olast) |-> (r_opeak == '0))
        else $error("peak frequency on a result that is not last");

    a_last_cell_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_oval && r_olast) |-> (({1'b0, r_ocell} + 1'b1) == n_cells))
        else $error("last result does not describe the last cell");

    a_read_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SUM || r_state == ST_XING) |-> (r_j <= r_n))
        else $error("window read count past stored samples");
`endif

endmodule

FILE: dv/wzcf_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wzcf_checker: result predictor and scoreboard for the frequency unit
// Watches the config, input and result channels, keeps its own copy of the
// per-cell sample rings, and compares every result transaction with the
// oldest predicted result.
// ----------------------------------------------------------------------------
module wzcf_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic                              i_stall_in,
    input  logic                              i_kind,
    input  logic signed [wzcf_pkg::SMP_W-1:0] i_sample_value,
    input  logic                              i_res_valid,
    input  logic                              i_res_stall,
    input  logic [wzcf_pkg::CELL_W-1:0]       i_cell_index,
    input  logic [wzcf_pkg::FREQ_W-1:0]       i_freq_q8,
    input  logic                              i_active,
    input  logic [wzcf_pkg::FREQ_W-1:0]       i_peak_freq_q8,
    input  logic                              i_last,
    input  logic                              i_cfg_valid,
    input  logic                              i_cfg_ready,
    input  logic [1:0]                        i_cfg_index,
    input  logic [31:0]                       i_cfg_data,
    output int                                o_fail_count,
    output int                                o_pending,
    output int                                o_result_count
);

    typedef struct packed {
        logic [wzcf_pkg::CELL_W-1:0] cell_idx;
        logic [wzcf_pkg::FREQ_W-1:0] freq;
        logic                        act;
        logic [wzcf_pkg::FREQ_W-1:0] peak;
        logic                        last;
    } t_cell_result;

    t_cell_result                  cell_results_q[$];
    logic signed [15:0]            ring[wzcf_pkg::DEPTH];
    int unsigned                   wr_pos, fill, next_cell;
    logic [wzcf_pkg::RATE_W-1:0]   rate;
    logic [wzcf_pkg::CIU_W-1:0]    cells_cfg;
    logic [wzcf_pkg::THR_W-1:0]    thresh;

    function automatic int unsigned cells_active();
        if (cells_cfg == 0) return 1;
        if (cells_cfg > wzcf_pkg::MAX_CELLS) return wzcf_pkg::MAX_CELLS;
        return cells_cfg;
    endfunction

    // Store one sample into the next cell and advance the frame position
    task automatic store_sample(logic signed [15:0] v);
        int unsigned cur;
        cur = next_cell % wzcf_pkg::MAX_CELLS;
        ring[cur * wzcf_pkg::WINDOW + (wr_pos % wzcf_pkg::WINDOW)] = v;
        if (cur + 1 >= cells_active()) begin
            next_cell = 0;
            wr_pos = (wr_pos + 1) % wzcf_pkg::WINDOW;
            if (fill < wzcf_pkg::WINDOW) fill++;
        end else begin
            next_cell = cur + 1;
        end
    endtask

    // Predict every cell result of one analysis transaction
    task automatic predict_analysis();
        int unsigned       cells, n, zc, idx;
        longint            s, x, xs[wzcf_pkg::WINDOW];
        longint unsigned   q, d, lim, freq, peak;
        logic              act, pn, cn;
        t_cell_result      r;
        cells = cells_active();
        n = fill;
        peak = 0;
        for (int c = 0; c < cells; c++) begin
            freq = 0;
            act = 1'b0;
            if (n >= wzcf_pkg::MIN_N) begin
                s = 0;
                q = 0;
                zc = 0;
                for (int j = 0; j < n; j++) begin
                    idx = (wr_pos + wzcf_pkg::WINDOW - n + j) % wzcf_pkg::WINDOW;
                    x = ring[c * wzcf_pkg::WINDOW + idx];
                    xs[j] = x;
                    s += x;
                    q += longint'(x * x);
                end
                for (int j = 1; j < n; j++) begin
                    pn = (longint'(n) * xs[j-1] - s) >= 0;
                    cn = (longint'(n) * xs[j] - s) >= 0;
                    if (pn != cn) zc++;
                end
                d = longint'(n) * q - longint'(s * s);
                lim = longint'(thresh) * n * n;
                act = d > lim;
                freq = (longint'(zc) * rate * 128) / n;
                freq &= 64'h7F_FFFF;
                if (act && freq > peak) peak = freq;
            end
            r.cell_idx = c[wzcf_pkg::CELL_W-1:0];
            r.freq = freq[wzcf_pkg::FREQ_W-1:0];
            r.act  = act;
            r.peak = '0;
            r.last = 1'b0;
            if (c == cells - 1) begin
                r.peak = peak[wzcf_pkg::FREQ_W-1:0];
                r.last = 1'b1;
            end
            cell_results_q.push_back(r);
        end
    endtask

    // Compare one field and count a mismatch
    task automatic check_field(string name, longint unsigned exp, longint unsigned act);
        if (exp !== act) begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp, act);
            o_fail_count++;
        end
    endtask

    initial begin
        o_fail_count = 0;
        o_pending = 0;
        o_result_count = 0;
    end

    always @(posedge i_clk) begin
        t_cell_result e;
        if (!i_rst_n) begin
            foreach (ring[k]) ring[k] = '0;
            wr_pos = 0;
            fill = 0;
            next_cell = 0;
            rate = 16'd1000;
            cells_cfg = 7'd64;
            thresh = '0;
            cell_results_q.delete();
        end else begin
            // Register writes
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    wzcf_pkg::REG_SAMPLE_RATE:  rate = i_cfg_data[wzcf_pkg::RATE_W-1:0];
                    wzcf_pkg::REG_CELLS_IN_USE: cells_cfg = i_cfg_data[wzcf_pkg::CIU_W-1:0];
                    wzcf_pkg::REG_VAR_THRESH:   thresh = i_cfg_data;
                    default: ;
                endcase
            end
            // Result transactions
            if (i_res_valid && !i_res_stall) begin
                o_result_count++;
                if (cell_results_q.size() == 0) begin
                    $error("result with no expectation: cell %0d", i_cell_index);
                    o_fail_count++;
                end else begin
                    e = cell_results_q.pop_front();
                    check_field("cell_index", e.cell_idx, i_cell_index);
                    check_field("freq_q8", e.freq, i_freq_q8);
                    check_field("active", e.act, i_active);
                    check_field("peak_freq_q8", e.peak, i_peak_freq_q8);
                    check_field("last", e.last, i_last);
                end
            end
            // Input transactions
            if (i_valid && !i_stall_in) begin
                if (i_kind) predict_analysis();
                else store_sample(i_sample_value);
            end
        end
        o_pending = cell_results_q.size();
    end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench top for the zero-crossing frequency unit
// Drives sample and analysis transactions under several register settings
// and idling regimes; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;

    localparam int CYCLE_LIMIT = 5000000;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               i_valid = 1'b0;
    logic                               o_stall;
    logic                               i_kind = 1'b0;
    logic signed [wzcf_pkg::SMP_W-1:0]  i_sample_value = '0;
    logic                               o_valid;
    logic                               i_stall = 1'b0;
    logic [wzcf_pkg::CELL_W-1:0]        o_cell_index;
    logic [wzcf_pkg::FREQ_W-1:0]        o_freq_q8;
    logic                               o_active;
    logic [wzcf_pkg::FREQ_W-1:0]        o_peak_freq_q8;
    logic                               o_last;
    logic                               i_cfg_valid = 1'b0;
    logic                               o_cfg_ready;
    logic [1:0]                         i_cfg_index = '0;
    logic [31:0]                        i_cfg_data = '0;

    int fail_count, pending, result_count;
    int tx_pct = 0, rx_pct = 0;
    int hold_req = 0, hold_seen = 0, hold_left = 0;
    int item_count = 0, analysis_count = 0, cycles = 0;

    windowed_zero_crossing_frequency_unit dut (.*);

    wzcf_checker u_checker (
        .i_clk, .i_rst_n, .i_valid, .i_stall_in(o_stall), .i_kind, .i_sample_value,
        .i_res_valid(o_valid), .i_res_stall(i_stall), .i_cell_index(o_cell_index),
        .i_freq_q8(o_freq_q8), .i_active(o_active), .i_peak_freq_q8(o_peak_freq_q8),
        .i_last(o_last), .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index,
        .i_cfg_data, .o_fail_count(fail_count), .o_pending(pending),
        .o_result_count(result_count)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Receiver: random stall, with a long hold-off on request
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (hold_seen != hold_req) begin
            hold_seen = hold_req;
            hold_left = 400;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < rx_pct);
        end
    end

    // Offer one transaction, idling first at random; return at the falling edge
    task automatic send(logic kind, logic [15:0] value);
        while ($urandom_range(99) < tx_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_kind <= kind;
        i_sample_value <= value;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
        item_count++;
        if (kind) analysis_count++;
    endtask

    // Hold off input until every predicted result has arrived
    task automatic drain();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic cfg_write(logic [1:0] index, logic [31:0] data);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // Sample shapes: full-range noise, noisy square wave, flat
    function automatic logic [15:0] make_sample(int mode, int amp);
        int v;
        case (mode)
            0: return 16'($urandom);
            1: begin
                v = $urandom_range(1) ? amp : -amp;
                v += int'($urandom_range(64)) - 32;
                return 16'(v);
            end
            default: return 16'(amp);
        endcase
    endfunction

    // One random phase: frames of pushes with the odd analysis and stray noise
    task automatic random_phase(int items, int cells, logic long_hold);
        int mode, amp, sent;
        logic held;
        mode = $urandom_range(2);
        amp = $urandom_range(32767);
        sent = 0;
        held = 1'b0;
        while (sent < items) begin
            if (long_hold && !held && sent >= items / 2) begin
                hold_req++;
                held = 1'b1;
            end
            if ($urandom_range(99) < 8) begin
                send(1'b1, 16'($urandom));
                sent++;
            end else begin
                for (int c = 0; c < cells && sent < items; c++) begin
                    send(1'b0, make_sample(($urandom_range(9) == 0) ? 0 : mode, amp));
                    sent++;
                end
            end
        end
        send(1'b1, 16'($urandom));
    endtask

    initial begin
        int phase_cells;
        // Reset, then directed cases
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Analysis with nothing stored: all cells report zero
        send(1'b1, 16'h0000);
        cfg_write(wzcf_pkg::REG_CELLS_IN_USE, 32'hFFFF_FF82);
        cfg_write(wzcf_pkg::REG_SAMPLE_RATE, 32'd65535);
        cfg_write(wzcf_pkg::REG_VAR_THRESH, 32'hFFFF_FFFF);
        // Extreme swings in cell 0, flat cell 1
        for (int k = 0; k < 8; k++) begin
            send(1'b0, (k % 2) ? 16'h8000 : 16'h7FFF);
            send(1'b0, 16'h0000);
        end
        send(1'b1, 16'hFFFF);
        cfg_write(wzcf_pkg::REG_VAR_THRESH, 32'd0);
        send(1'b1, 16'h1234);
        // Zero cell count acts as one cell
        cfg_write(wzcf_pkg::REG_CELLS_IN_USE, 32'd0);
        send(1'b0, 16'h7FFF);
        send(1'b1, 16'h0000);
        // Cell count above the maximum acts as the maximum
        cfg_write(wzcf_pkg::REG_CELLS_IN_USE, 32'd127);
        send(1'b1, 16'h0000);
        // Shrink the cell count mid-frame
        cfg_write(wzcf_pkg::REG_CELLS_IN_USE, 32'd4);
        send(1'b0, 16'h0100);
        send(1'b0, 16'hFF00);
        cfg_write(wzcf_pkg::REG_CELLS_IN_USE, 32'd1);
        send(1'b0, 16'h8001);
        send(1'b0, 16'h7FFE);
        // Zero rate and an index beyond the register list
        cfg_write(wzcf_pkg::REG_SAMPLE_RATE, 32'd0);
        cfg_write(2'd3, 32'hDEAD_BEEF);
        send(1'b1, 16'h0000);

        // Random phases under three idling regimes
        for (int regime = 0; regime < 3; regime++) begin
            for (int ph = 0; ph < 2; ph++) begin
                drain();
                tx_pct = (regime == 0) ? 27 : (regime == 1) ? 83 : 0;
                rx_pct = (regime == 0) ? 83 : (regime == 1) ? 27 : 0;
                phase_cells = (regime == 2 && ph == 1) ? 64 : $urandom_range(1, 8);
                cfg_write(wzcf_pkg::REG_CELLS_IN_USE, 32'(phase_cells));
                cfg_write(wzcf_pkg::REG_SAMPLE_RATE,
                          (ph == 0) ? 32'($urandom_range(1, 65535)) : 32'd65535);
                cfg_write(wzcf_pkg::REG_VAR_THRESH,
                          ($urandom_range(3) == 0) ? 32'hFFFF_FFFF
                                                   : 32'($urandom_range(0, 1 << 20)));
                random_phase((phase_cells == 64) ? 70 : 55, phase_cells, ph == 0);
            end
        end

        // Wait for the last results, then give the verdict
        drain();
        repeat (200) @(negedge i_clk);
        $display("Run covered %0d transactions (%0d analyses) and %0d results.",
                 item_count, analysis_count, result_count);
        $display("Settings: extremes of rate, cell count and threshold; 3 idling regimes.");
        if (fail_count == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/wzcf_pkg.sv
hw/rtl/wzcf_ram.sv
hw/rtl/wzcf_div.sv
hw/rtl/windowed_zero_crossing_frequency_unit.sv
dv/wzcf_checker.sv
dv/tb.sv
